// ===== sv/sawcd_pkg.sv =====
package sawcd_pkg;

    localparam int MAX_SETS_DEF = 64;
    localparam int WAYS_DEF     = 4;
    localparam int AGE_BITS_DEF = 8;

    localparam int ADDR_W       = 32;
    localparam int TAG_W        = 32;
    localparam int CFG_W        = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [CFG_W-1:0] OFFSET_LIMIT    = 3'd4;
    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 3'd3;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 3'd6;

    typedef enum logic [1:0] {
        CMD_READ_WORD   = 2'd0,
        CMD_READ_BLOCK  = 2'd1,
        CMD_WRITE_WORD  = 2'd2,
        CMD_WRITE_BLOCK = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_OFFSET_BITS = 1'b0,
        REG_INDEX_BITS  = 1'b1
    } t_reg_sel;

    typedef struct packed {
        logic [CFG_W-1:0] offset_bits;
        logic [CFG_W-1:0] index_bits;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [1:0]        way;
        logic              fill_needed;
        logic              writeback_needed;
        logic [ADDR_W-1:0] writeback_addr;
        logic [3:0]        word_offset;
    } t_result;

endpackage

// ===== sv/sawcd_cfg_regs.sv =====
module sawcd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sawcd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sawcd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sawcd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output sawcd_pkg::t_cfg                     o_cfg
);

    sawcd_pkg::t_cfg  r_cfg;
    sawcd_pkg::t_cfg  n_cfg;
    sawcd_pkg::t_reg_sel sel;

    assign sel    = sawcd_pkg::t_reg_sel'(paddr[2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (sel)
                sawcd_pkg::REG_OFFSET_BITS: n_cfg.offset_bits = pwdata[sawcd_pkg::CFG_W-1:0];
                sawcd_pkg::REG_INDEX_BITS:  n_cfg.index_bits  = pwdata[sawcd_pkg::CFG_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (sel)
            sawcd_pkg::REG_OFFSET_BITS:
                prdata = {{(sawcd_pkg::APB_DATA_W-sawcd_pkg::CFG_W){1'b0}}, r_cfg.offset_bits};
            sawcd_pkg::REG_INDEX_BITS:
                prdata = {{(sawcd_pkg::APB_DATA_W-sawcd_pkg::CFG_W){1'b0}}, r_cfg.index_bits};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_bits <= sawcd_pkg::OFFSET_BITS_RST;
            r_cfg.index_bits  <= sawcd_pkg::INDEX_BITS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== sv/sawcd_dir_ram.sv =====
module sawcd_dir_ram #(
    parameter int DEPTH  = sawcd_pkg::MAX_SETS_DEF,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 168
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  r_row_valid;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_rowv;

    assign o_rd_data = r_rd_rowv ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_rowv   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_rowv <= r_row_valid[i_rd_addr];
            end
        end
    end

endmodule

// ===== sv/sawcd_lookup.sv =====
module sawcd_lookup #(
    parameter int WAYS     = sawcd_pkg::WAYS_DEF,
    parameter int AGE_BITS = sawcd_pkg::AGE_BITS_DEF,
    parameter int SET_W    = 6,
    parameter int ENT_W    = sawcd_pkg::TAG_W + AGE_BITS + 2
) (
    input  logic [1:0]                       i_cmd,
    input  logic [sawcd_pkg::ADDR_W-1:0]     i_addr,
    input  logic [sawcd_pkg::CFG_W-1:0]      i_ob,
    input  logic [sawcd_pkg::CFG_W-1:0]      i_ib,
    input  logic [SET_W-1:0]                 i_set,
    input  logic [WAYS-1:0][ENT_W-1:0]       i_row,
    output logic [WAYS-1:0][ENT_W-1:0]       o_row,
    output sawcd_pkg::t_result               o_res
);

    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_LSB   = sawcd_pkg::TAG_W;
    localparam int DIRTY_BIT = sawcd_pkg::TAG_W + AGE_BITS;
    localparam int VALID_BIT = sawcd_pkg::TAG_W + AGE_BITS + 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [3:0]                    shift;
    logic [sawcd_pkg::TAG_W-1:0]   tag;
    logic                          is_write;
    logic                          hit;
    logic                          found_empty;
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              empty_way;
    logic [WAY_W-1:0]              old_way;
    logic [WAY_W-1:0]              sel;
    logic [ENT_W-1:0]              vic;
    logic                          wb;
    logic [3:0]                    omask;

    always_comb begin
        shift    = {1'b0, i_ob} + {1'b0, i_ib};
        tag      = i_addr >> shift;
        is_write = (i_cmd == sawcd_pkg::CMD_WRITE_WORD) || (i_cmd == sawcd_pkg::CMD_WRITE_BLOCK);
        omask    = ~(4'hF << i_ob);

        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_row[w][VALID_BIT] && i_row[w][AGE_LSB-1:0] == tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        found_empty = 1'b0;
        empty_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!i_row[w][VALID_BIT]) begin
                found_empty = 1'b1;
                empty_way   = WAY_W'(w);
            end
        end

        old_way = '0;
        for (int w = 1; w < WAYS; w++) begin
            if (i_row[w][AGE_LSB +: AGE_BITS] > i_row[old_way][AGE_LSB +: AGE_BITS]) begin
                old_way = WAY_W'(w);
            end
        end

        sel = hit ? hit_way : (found_empty ? empty_way : old_way);
        vic = i_row[sel];
        wb  = !hit && vic[VALID_BIT] && vic[DIRTY_BIT];

        o_row = i_row;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == sel) begin
                o_row[w][VALID_BIT]             = 1'b1;
                o_row[w][AGE_LSB +: AGE_BITS]   = '0;
                o_row[w][DIRTY_BIT]             = hit ? (i_row[w][DIRTY_BIT] | is_write)
                                                      : is_write;
                if (!hit) begin
                    o_row[w][AGE_LSB-1:0] = tag;
                end
            end else if (i_row[w][VALID_BIT] && i_row[w][AGE_LSB +: AGE_BITS] != AGE_MAX) begin
                o_row[w][AGE_LSB +: AGE_BITS] = i_row[w][AGE_LSB +: AGE_BITS] + 1'b1;
            end
        end

        o_res.hit              = hit;
        o_res.way              = 2'(sel);
        o_res.fill_needed      = !hit && (i_cmd != sawcd_pkg::CMD_WRITE_BLOCK);
        o_res.writeback_needed = wb;
        o_res.writeback_addr   = wb ? ((vic[AGE_LSB-1:0] << shift)
                                       | (sawcd_pkg::ADDR_W'(i_set) << i_ob)) : '0;
        o_res.word_offset      = i_addr[3:0] & omask;
    end

endmodule

// ===== sv/set_assoc_writeback_cache_directory_core.sv =====
// Channel   Direction  Handshake                 Payload
// access    in         i_in_valid / o_in_stall   i_cmd, i_addr
// result    out        o_out_valid / i_out_stall o_hit, o_way, o_fill_needed,
//                                                o_writeback_needed, o_writeback_addr,
//                                                o_word_offset
// config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled; each item passes
// through the registered directory RAM read, then compare, victim pick and row
// update, which is written back as the result register loads.
// A row written in the same cycle as the next item's read of the same set is forwarded.
// Reset clears all per-set row valid flops at once, so no clearing pass is needed.
// A stalled result holds the lookup stage, and the input stalls only when that
// stage cannot move on.
module set_assoc_writeback_cache_directory_core #(
    parameter int MAX_SETS = sawcd_pkg::MAX_SETS_DEF,
    parameter int WAYS     = sawcd_pkg::WAYS_DEF,
    parameter int AGE_BITS = sawcd_pkg::AGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_cmd,
    input  logic [sawcd_pkg::ADDR_W-1:0]      i_addr,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic [1:0]                        o_way,
    output logic                              o_fill_needed,
    output logic                              o_writeback_needed,
    output logic [sawcd_pkg::ADDR_W-1:0]      o_writeback_addr,
    output logic [3:0]                        o_word_offset,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sawcd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sawcd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sawcd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int IDX_LIM = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_W   = (IDX_LIM > 0) ? IDX_LIM : 1;
    localparam int ENT_W   = sawcd_pkg::TAG_W + AGE_BITS + 2;
    localparam int ROW_W   = WAYS * ENT_W;

    sawcd_pkg::t_cfg                 cfg;
    logic [sawcd_pkg::CFG_W-1:0]     ob_c;
    logic [sawcd_pkg::CFG_W-1:0]     ib_c;
    logic [SET_W-1:0]                set_in;
    logic                            accept_in;
    logic                            adv;

    logic                            r_s1_valid;
    logic [1:0]                      r_cmd;
    logic [sawcd_pkg::ADDR_W-1:0]    r_addr;
    logic [SET_W-1:0]                r_set;
    logic                            r_byp;
    logic [WAYS-1:0][ENT_W-1:0]      r_byp_row;

    logic [ROW_W-1:0]                rd_data;
    logic [WAYS-1:0][ENT_W-1:0]      row_cur;
    logic [WAYS-1:0][ENT_W-1:0]      row_new;
    sawcd_pkg::t_result              res;

    logic                            r_out_valid;
    sawcd_pkg::t_result              r_res;

    sawcd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign ob_c = (cfg.offset_bits > sawcd_pkg::OFFSET_LIMIT) ? sawcd_pkg::OFFSET_LIMIT
                                                             : cfg.offset_bits;
    assign ib_c = (32'(cfg.index_bits) > IDX_LIM) ? sawcd_pkg::CFG_W'(IDX_LIM)
                                                  : cfg.index_bits;
    assign set_in = SET_W'((i_addr >> ob_c) & ((32'd1 << ib_c) - 32'd1));

    assign adv        = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv;
    assign accept_in  = i_in_valid && !o_in_stall;

    sawcd_dir_ram #(
        .DEPTH  (MAX_SETS),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept_in),
        .i_rd_addr (set_in),
        .o_rd_data (rd_data),
        .i_wr_en   (adv),
        .i_wr_addr (r_set),
        .i_wr_data (row_new)
    );

    assign row_cur = r_byp ? r_byp_row : rd_data;

    sawcd_lookup #(
        .WAYS     (WAYS),
        .AGE_BITS (AGE_BITS),
        .SET_W    (SET_W),
        .ENT_W    (ENT_W)
    ) u_lookup (
        .i_cmd  (r_cmd),
        .i_addr (r_addr),
        .i_ob   (ob_c),
        .i_ib   (ib_c),
        .i_set  (r_set),
        .i_row  (row_cur),
        .o_row  (row_new),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_cmd     <= i_cmd;
            r_addr    <= i_addr;
            r_set     <= set_in;
            r_byp_row <= row_new;
        end
        if (adv) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_s1_valid <= 1'b1;
                r_byp      <= adv && (r_set == set_in);
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_res.hit;
    assign o_way              = r_res.way;
    assign o_fill_needed      = r_res.fill_needed;
    assign o_writeback_needed = r_res.writeback_needed;
    assign o_writeback_addr   = r_res.writeback_addr;
    assign o_word_offset      = r_res.word_offset;

    a_adv_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("lookup result not registered");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in |=> r_s1_valid)
        else $error("accepted item lost from lookup stage");

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.hit) |-> (!r_res.fill_needed && !r_res.writeback_needed))
        else $error("hit reports fill or writeback");

    a_wb_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.writeback_needed) |-> (r_res.writeback_addr == '0))
        else $error("writeback address without writeback");

endmodule
